// File: rtl/rbws_pkg.sv
// Shared types and constants for the rotating block work split.
// No dependencies; used by rbws_divider and rotating_block_work_split.
package rbws_pkg;

  localparam int unsigned COUNT_BITS_DEF = 32;
  localparam int unsigned RANK_BITS_DEF  = 16;

  // Request kinds carried on tuser
  localparam logic ACT_DISTRIBUTE = 1'b0;
  localparam logic ACT_CLEAR      = 1'b1;

  // Configuration register indexes
  localparam int unsigned CFG_IDX_BITS = 1;
  localparam logic [CFG_IDX_BITS-1:0] REG_WORKER_COUNT = 1'b0;
  localparam logic [CFG_IDX_BITS-1:0] REG_OWN_RANK     = 1'b1;

  // Divider control from the sequencer
  typedef struct packed {
    logic load;  // start a new division from value_i
    logic step;  // retire one quotient bit
  } div_ctrl_t;

endpackage

// File: rtl/rbws_divider.sv
// Bit-serial restoring divider with a Horner multiply of the quotient.
// Depends on rbws_pkg (div_ctrl_t).
module rbws_divider #(
  parameter int unsigned COUNT_BITS = rbws_pkg::COUNT_BITS_DEF,
  parameter int unsigned RANK_BITS  = rbws_pkg::RANK_BITS_DEF,
  localparam int unsigned DW = (COUNT_BITS > RANK_BITS) ? COUNT_BITS : RANK_BITS,
  localparam int unsigned WB = RANK_BITS + 1
) (
  input  logic                  clk_i,
  input  rbws_pkg::div_ctrl_t   ctrl_i,
  input  logic [DW-1:0]         value_i,    // dividend, left aligned
  input  logic [WB-1:0]         divisor_i,
  input  logic [RANK_BITS-1:0]  mult_i,     // factor applied to the quotient
  output logic [RANK_BITS-1:0]  rem_o,
  output logic [COUNT_BITS-1:0] quo_o,
  output logic [COUNT_BITS-1:0] prod_o      // mult_i * quotient, truncated
);

  logic [DW-1:0]         dvd_q, dvd_d;
  logic [RANK_BITS-1:0]  rem_q, rem_d;
  logic [COUNT_BITS-1:0] quo_q, quo_d;
  logic [COUNT_BITS-1:0] prod_q, prod_d;

  logic [WB-1:0]         trial;
  logic [WB-1:0]         diff;
  logic                  ge;
  logic [DW-1:0]         mult_ext;
  logic [COUNT_BITS-1:0] addend;

  always_comb begin
    trial    = {rem_q, dvd_q[DW-1]};
    diff     = trial - divisor_i;
    ge       = (trial >= divisor_i);
    mult_ext = DW'(mult_i);
    addend   = ge ? mult_ext[COUNT_BITS-1:0] : '0;

    dvd_d  = dvd_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    prod_d = prod_q;
    if (ctrl_i.load) begin
      dvd_d  = value_i;
      rem_d  = '0;
      quo_d  = '0;
      prod_d = '0;
    end else if (ctrl_i.step) begin
      dvd_d  = {dvd_q[DW-2:0], 1'b0};
      rem_d  = ge ? diff[RANK_BITS-1:0] : trial[RANK_BITS-1:0];
      quo_d  = {quo_q[COUNT_BITS-2:0], ge};
      // quotient bits arrive MSB first, so double and add
      prod_d = {prod_q[COUNT_BITS-2:0], 1'b0} + addend;
    end
  end

  always_ff @(posedge clk_i) begin
    dvd_q  <= dvd_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    prod_q <= prod_d;
  end

  assign rem_o  = rem_q;
  assign quo_o  = quo_q;
  assign prod_o = prod_q;

endmodule

// File: rtl/rbws_share.sv
// Final share computation: remainder placement, local count, first index.
// No package dependency; fed by rbws_divider results.
module rbws_share #(
  parameter int unsigned COUNT_BITS = 32,
  parameter int unsigned RANK_BITS  = 16,
  localparam int unsigned DW = (COUNT_BITS > RANK_BITS) ? COUNT_BITS : RANK_BITS,
  localparam int unsigned WB = RANK_BITS + 1
) (
  input  logic [WB-1:0]         workers_i,
  input  logic [RANK_BITS-1:0]  rank_i,
  input  logic [RANK_BITS-1:0]  offset_i,   // reduced offset
  input  logic [RANK_BITS-1:0]  rem_i,
  input  logic [COUNT_BITS-1:0] quo_i,
  input  logic [COUNT_BITS-1:0] prod_i,     // rank * quotient
  input  logic [COUNT_BITS-1:0] count_i,
  output logic [COUNT_BITS-1:0] local_count_o,
  output logic [COUNT_BITS-1:0] first_index_o,
  output logic [RANK_BITS-1:0]  offset_next_o
);

  logic [WB-1:0]        sum, sum_sub;
  logic [RANK_BITS-1:0] a_next;
  logic                 extra;
  logic [RANK_BITS-1:0] extras_prior;
  logic [DW-1:0]        before_ext;

  always_comb begin
    sum     = {1'b0, offset_i} + {1'b0, rem_i};
    sum_sub = sum - workers_i;
    a_next  = (sum >= workers_i) ? sum_sub[RANK_BITS-1:0] : sum[RANK_BITS-1:0];

    if (a_next >= offset_i) begin
      // extras sit on ranks offset .. a_next-1
      extra = (rank_i >= offset_i) && (rank_i < a_next);
      if (rank_i < offset_i)     extras_prior = '0;
      else if (rank_i >= a_next) extras_prior = rem_i;
      else                       extras_prior = rank_i - offset_i;
    end else begin
      // extras wrap: ranks 0 .. a_next-1 and offset .. workers-1
      extra = (rank_i < a_next) || (rank_i >= offset_i);
      if (rank_i < a_next)        extras_prior = rank_i;
      else if (rank_i < offset_i) extras_prior = a_next;
      else                        extras_prior = a_next + (rank_i - offset_i);
    end
    before_ext = DW'(extras_prior);

    if ({1'b0, rank_i} >= workers_i) begin
      local_count_o = '0;
      first_index_o = count_i;
    end else begin
      local_count_o = quo_i + COUNT_BITS'(extra);
      first_index_o = prod_i + before_ext[COUNT_BITS-1:0];
    end
    offset_next_o = a_next;
  end

endmodule

// File: rtl/rotating_block_work_split.sv
// Rotating block work split: splits each batch of elem_count elements over
// worker_count workers. Every worker gets the floor share; the remainder goes
// one element each to consecutive workers starting at a rotation offset that
// wraps around and advances by the batch size after each batch. For own_rank
// the block returns local_count and first_index (ranks counted in order).
// A clear request (tuser = 1) zeroes the offset and returns zeros.
// Timing: one request at a time. A distribute request runs through the
// bit-serial divider (ST_DIVIDE), which retires one quotient bit per cycle,
// then ST_FINISH; the product rank * quotient is formed in the same pass.
// If the stored offset is not below the worker count (after a
// reconfiguration) it is first reduced on the same divider (ST_REDUCE, then
// ST_RELOAD). A clear request goes straight to ST_FINISH. The result
// sits in an output register, so the next request is accepted while a
// result waits. Configuration writes are always taken; change them only
// while idle. Depends on rbws_pkg, rbws_divider, rbws_share.
module rotating_block_work_split #(
  parameter int unsigned COUNT_BITS = rbws_pkg::COUNT_BITS_DEF,
  parameter int unsigned RANK_BITS  = rbws_pkg::RANK_BITS_DEF,
  localparam int unsigned WB    = RANK_BITS + 1,
  localparam int unsigned IN_W  = ((COUNT_BITS + 7) / 8) * 8,
  localparam int unsigned OUT_W = ((2 * COUNT_BITS + 7) / 8) * 8
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // request stream
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  input  logic [IN_W-1:0]                   s_axis_tdata,  // elem_count
  input  logic                              s_axis_tuser,  // action
  // result stream
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  output logic [OUT_W-1:0]                  m_axis_tdata,  // local_count, first_index
  // configuration writes
  input  logic                              cfg_valid_i,
  output logic                              cfg_ready_o,
  input  logic [rbws_pkg::CFG_IDX_BITS-1:0] cfg_index_i,
  input  logic [WB-1:0]                     cfg_data_i
);

  localparam int unsigned DW    = (COUNT_BITS > RANK_BITS) ? COUNT_BITS : RANK_BITS;
  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [CNT_W-1:0] COUNT_STEPS = CNT_W'(COUNT_BITS);
  localparam logic [CNT_W-1:0] RANK_STEPS  = CNT_W'(RANK_BITS);
  localparam logic [WB-1:0]    WORKERS_MAX = {1'b1, {RANK_BITS{1'b0}}};
  localparam logic [WB-1:0]    WORKERS_ONE = WB'(1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_REDUCE = 3'd1;  // reduce a stale offset
  localparam logic [2:0] ST_RELOAD = 3'd2;  // capture reduced offset, load count
  localparam logic [2:0] ST_DIVIDE = 3'd3;
  localparam logic [2:0] ST_FINISH = 3'd4;

  // control state
  logic [2:0]           state_q, state_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;
  logic                 m_valid_q, m_valid_d;
  logic [RANK_BITS-1:0] offset_q, offset_d;
  logic [WB-1:0]        workers_cfg_q;
  logic [RANK_BITS-1:0] rank_cfg_q;

  // per-request payload
  logic [COUNT_BITS-1:0] n_q;
  logic                  clr_q;
  logic [WB-1:0]         w_q;
  logic [RANK_BITS-1:0]  p_q;
  logic [RANK_BITS-1:0]  a_q;
  logic [COUNT_BITS-1:0] local_q, first_q;

  logic                  s_fire, fin_fire, stale;
  logic [WB-1:0]         w_eff;
  logic [COUNT_BITS-1:0] n_in;
  logic [DW-1:0]         div_value;
  rbws_pkg::div_ctrl_t   div_ctrl;
  logic [RANK_BITS-1:0]  div_rem;
  logic [COUNT_BITS-1:0] div_quo, div_prod;
  logic [COUNT_BITS-1:0] sh_local, sh_first;
  logic [RANK_BITS-1:0]  sh_offset;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = (state_q == ST_IDLE);
  assign s_fire        = s_axis_tvalid && s_axis_tready;
  assign fin_fire      = (state_q == ST_FINISH) && (!m_valid_q || m_axis_tready);
  assign n_in          = s_axis_tdata[COUNT_BITS-1:0];

  // zero workers acts as one; anything above 2^RANK_BITS saturates
  always_comb begin
    if (workers_cfg_q == '0)           w_eff = WORKERS_ONE;
    else if (workers_cfg_q > WORKERS_MAX) w_eff = WORKERS_MAX;
    else                               w_eff = workers_cfg_q;
  end
  assign stale = ({1'b0, offset_q} >= w_eff);

  // sequencer
  always_comb begin
    state_d   = state_q;
    cnt_d     = cnt_q;
    m_valid_d = m_valid_q;
    offset_d  = offset_q;
    div_ctrl  = '0;
    div_value = DW'(n_q) << (DW - COUNT_BITS);
    if (m_valid_q && m_axis_tready) m_valid_d = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        if (s_fire) begin
          if (s_axis_tuser == rbws_pkg::ACT_CLEAR) begin
            state_d = ST_FINISH;
          end else if (stale) begin
            div_ctrl.load = 1'b1;
            div_value     = DW'(offset_q) << (DW - RANK_BITS);
            cnt_d         = RANK_STEPS;
            state_d       = ST_REDUCE;
          end else begin
            div_ctrl.load = 1'b1;
            div_value     = DW'(n_in) << (DW - COUNT_BITS);
            cnt_d         = COUNT_STEPS;
            state_d       = ST_DIVIDE;
          end
        end
      end
      ST_REDUCE: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = ST_RELOAD;
      end
      ST_RELOAD: begin
        div_ctrl.load = 1'b1;
        cnt_d         = COUNT_STEPS;
        state_d       = ST_DIVIDE;
      end
      ST_DIVIDE: begin
        div_ctrl.step = 1'b1;
        cnt_d         = cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (fin_fire) begin
          m_valid_d = 1'b1;
          offset_d  = clr_q ? '0 : sh_offset;
          state_d   = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_IDLE;
      cnt_q         <= '0;
      m_valid_q     <= 1'b0;
      offset_q      <= '0;
      workers_cfg_q <= WORKERS_ONE;
      rank_cfg_q    <= '0;
    end else begin
      state_q   <= state_d;
      cnt_q     <= cnt_d;
      m_valid_q <= m_valid_d;
      offset_q  <= offset_d;
      if (cfg_valid_i && cfg_ready_o) begin
        unique case (cfg_index_i)
          rbws_pkg::REG_WORKER_COUNT: workers_cfg_q <= cfg_data_i;
          rbws_pkg::REG_OWN_RANK:     rank_cfg_q    <= cfg_data_i[RANK_BITS-1:0];
          default: ;
        endcase
      end
    end
  end

  // request payload and result register
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      n_q   <= n_in;
      clr_q <= (s_axis_tuser == rbws_pkg::ACT_CLEAR);
      w_q   <= w_eff;
      p_q   <= rank_cfg_q;
      a_q   <= offset_q;
    end
    if (state_q == ST_RELOAD) a_q <= div_rem;
    if (fin_fire) begin
      local_q <= clr_q ? '0 : sh_local;
      first_q <= clr_q ? '0 : sh_first;
    end
  end

  rbws_divider #(
    .COUNT_BITS (COUNT_BITS),
    .RANK_BITS  (RANK_BITS)
  ) u_div (
    .clk_i     (clk_i),
    .ctrl_i    (div_ctrl),
    .value_i   (div_value),
    .divisor_i (w_q),
    .mult_i    (p_q),
    .rem_o     (div_rem),
    .quo_o     (div_quo),
    .prod_o    (div_prod)
  );

  rbws_share #(
    .COUNT_BITS (COUNT_BITS),
    .RANK_BITS  (RANK_BITS)
  ) u_share (
    .workers_i     (w_q),
    .rank_i        (p_q),
    .offset_i      (a_q),
    .rem_i         (div_rem),
    .quo_i         (div_quo),
    .prod_i        (div_prod),
    .count_i       (n_q),
    .local_count_o (sh_local),
    .first_index_o (sh_first),
    .offset_next_o (sh_offset)
  );

  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = OUT_W'({first_q, local_q});

  // offset left by a distribute request is always reduced
  a_offset_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && !clr_q) |=> ({1'b0, offset_q} < w_q))
    else $error("rotation offset not below worker count");

  // divider remainder stays below the divisor once a division is done
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_FINISH && !clr_q) |-> ({1'b0, div_rem} < w_q))
    else $error("remainder out of range");

  // a clear request returns zeros
  a_clear_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fin_fire && clr_q) |=> (local_q == '0 && first_q == '0 && offset_q == '0))
    else $error("clear result not zero");

  // finishing never overwrites a result still waiting
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_axis_tready && state_q == ST_FINISH) |=> (state_q == ST_FINISH))
    else $error("result overwritten while stalled");

endmodule
